/* rtl/core/ithp_pkg.sv */
// Shared types and constants for the IPv4/TCP header parser.
// No dependencies; every other file of the block uses this package.
package ithp_pkg;

    // Byte count of one packet, saturating at the maximum length
    localparam int unsigned LEN_W            = 16;
    localparam int unsigned MAX_PACKET_BYTES = 65535;

    typedef logic [LEN_W-1:0] t_len;

    localparam t_len LEN_MAX          = t_len'(MAX_PACKET_BYTES);
    localparam t_len MIN_PACKET_BYTES = t_len'(40);

    // Header constants
    localparam logic [3:0] IP_VERSION_4   = 4'd4;
    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [4:0] FRAG_HIGH_MASK = 5'h1f;
    localparam logic [3:0] NIBBLE_MASK    = 4'hf;
    localparam logic [5:0] MIN_HDR_BYTES  = 6'd20;

    // Byte positions inside the IPv4 header
    localparam t_len POS_VER_IHL  = t_len'(0);
    localparam t_len POS_FRAG_HI  = t_len'(6);
    localparam t_len POS_FRAG_LO  = t_len'(7);
    localparam t_len POS_PROTO    = t_len'(9);
    localparam t_len POS_SRC_ADDR = t_len'(12);
    localparam t_len POS_DST_ADDR = t_len'(16);
    localparam t_len POS_IP_END   = t_len'(20);

    // Byte positions inside the TCP header, relative to its start
    localparam t_len REL_DST_PORT = t_len'(2);
    localparam t_len REL_SEQ      = t_len'(4);
    localparam t_len REL_ACK      = t_len'(8);
    localparam t_len REL_DOFF     = t_len'(12);
    localparam t_len REL_FLAGS    = t_len'(13);

    // Result status codes
    typedef enum logic [1:0] {
        ST_REJECT     = 2'd0,
        ST_NO_MATCH   = 2'd1,
        ST_CLI_TO_SRV = 2'd2,
        ST_SRV_TO_CLI = 2'd3
    } t_status;

    // Configuration port
    localparam int unsigned APB_ADDR_W     = 3;
    localparam int unsigned APB_DATA_W     = 32;
    localparam logic        REG_SRV_PORT   = 1'b0;

    // Everything captured from one packet, handed over on its last byte
    typedef struct packed {
        t_len        len;
        logic        version_ok;
        logic [5:0]  ip_hdr_len;
        logic        proto_tcp;
        logic        frag_nonzero;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [5:0]  tcp_hdr_len;
    } t_pkt_rec;

    // One result item
    typedef struct packed {
        t_status     status;
        logic [31:0] cli_addr;
        logic [31:0] srv_addr;
        logic [15:0] cli_port;
        logic [15:0] srv_port;
        logic [7:0]  flag_byte;
        logic [31:0] sequence_after_header;
        logic [31:0] seq_raw;
        logic [31:0] acknowledgement;
        logic [6:0]  payload_offset;
        logic [15:0] pay_len;
    } t_result;

endpackage

/* rtl/core/ithp_if.sv */
// Valid/ready channel interfaces for packet bytes and parse results.
// Depends on ithp_pkg for field widths.
interface ithp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ithp_res_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [31:0]          cli_addr;
    logic [31:0]          srv_addr;
    logic [15:0]          cli_port;
    logic [15:0]          srv_port;
    logic [7:0]           flag_byte;
    logic [31:0]          sequence_after_header;
    logic [31:0]          seq_raw;
    logic [31:0]          acknowledgement;
    logic [6:0]           payload_offset;
    logic [ithp_pkg::LEN_W-1:0] pay_len;

    modport source (
        output valid, output status, output cli_addr, output srv_addr,
        output cli_port, output srv_port, output flag_byte,
        output sequence_after_header, output seq_raw, output acknowledgement,
        output payload_offset, output pay_len, input ready
    );
    modport sink (
        input valid, input status, input cli_addr, input srv_addr,
        input cli_port, input srv_port, input flag_byte,
        input sequence_after_header, input seq_raw, input acknowledgement,
        input payload_offset, input pay_len, output ready
    );
endinterface

/* rtl/core/ithp_apb_regs.sv */
// APB-style configuration register: the server TCP port.
// Depends on ithp_pkg for address/data widths and register index.
module ithp_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ithp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ithp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ithp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [15:0]                    o_srv_port
);
    import ithp_pkg::*;

    logic        reg_idx;
    logic        wr_en;
    logic [15:0] r_srv_port;

    assign reg_idx = paddr[APB_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready && (reg_idx == REG_SRV_PORT);

    // Write the server port on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srv_port <= '0;
        end else if (wr_en) begin
            r_srv_port <= pwdata[15:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_SRV_PORT) begin
            prdata = {{(APB_DATA_W-16){1'b0}}, r_srv_port};
        end
    end

    assign o_srv_port = r_srv_port;

endmodule

/* rtl/core/ithp_capture.sv */
// Byte capture stage: counts packet bytes, picks header fields out as they
// pass and hands a packet record over on the last byte. Depends on ithp_pkg.
module ithp_capture (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_ready,
    output logic               o_rec_valid,
    output ithp_pkg::t_pkt_rec o_rec,
    input  logic               i_rec_ready
);
    import ithp_pkg::*;

    t_len        r_byte_index, n_byte_index;
    logic        r_version_ok, n_version_ok;
    logic [5:0]  r_ip_hdr_len, n_ip_hdr_len;
    logic        r_proto_tcp, n_proto_tcp;
    logic        r_frag_nz, n_frag_nz;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [15:0] r_src_port, n_src_port;
    logic [15:0] r_dst_port, n_dst_port;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [7:0]  r_flags, n_flags;
    logic [5:0]  r_tcp_hdr_len, n_tcp_hdr_len;

    logic        r_rec_valid;
    t_pkt_rec    r_rec;
    t_pkt_rec    n_rec;

    logic        accept;
    t_len        pos;
    t_len        ihl_ext;
    t_len        rel;
    logic        in_tcp;

    assign o_ready = !r_rec_valid || i_rec_ready;
    assign accept  = i_valid && o_ready;

    assign pos     = r_byte_index;
    assign ihl_ext = {{(LEN_W-6){1'b0}}, r_ip_hdr_len};
    assign rel     = pos - ihl_ext;
    assign in_tcp  = pos >= ihl_ext;

    // Capture the current byte into the field it belongs to
    always_comb begin
        n_byte_index  = r_byte_index;
        n_version_ok  = r_version_ok;
        n_ip_hdr_len  = r_ip_hdr_len;
        n_proto_tcp   = r_proto_tcp;
        n_frag_nz     = r_frag_nz;
        n_src_addr    = r_src_addr;
        n_dst_addr    = r_dst_addr;
        n_src_port    = r_src_port;
        n_dst_port    = r_dst_port;
        n_seq         = r_seq;
        n_ack         = r_ack;
        n_flags       = r_flags;
        n_tcp_hdr_len = r_tcp_hdr_len;
        if (r_byte_index != LEN_MAX) begin
            n_byte_index = r_byte_index + t_len'(1);
            if (pos == POS_VER_IHL) begin
                n_version_ok = (i_data_byte[7:4] == IP_VERSION_4);
                n_ip_hdr_len = {i_data_byte[3:0] & NIBBLE_MASK, 2'b00};
            end else begin
                if (pos == POS_FRAG_HI) begin
                    n_frag_nz = |(i_data_byte[4:0] & FRAG_HIGH_MASK);
                end
                if (pos == POS_FRAG_LO) begin
                    n_frag_nz = r_frag_nz || (i_data_byte != 8'd0);
                end
                if (pos == POS_PROTO) begin
                    n_proto_tcp = (i_data_byte == PROTO_TCP);
                end
                if (pos >= POS_SRC_ADDR && pos < POS_DST_ADDR) begin
                    n_src_addr = {r_src_addr[23:0], i_data_byte};
                end
                if (pos >= POS_DST_ADDR && pos < POS_IP_END) begin
                    n_dst_addr = {r_dst_addr[23:0], i_data_byte};
                end
                // TCP header fields, relative to the captured IP header length
                if (in_tcp) begin
                    if (rel < REL_DST_PORT) begin
                        n_src_port = {r_src_port[7:0], i_data_byte};
                    end else if (rel < REL_SEQ) begin
                        n_dst_port = {r_dst_port[7:0], i_data_byte};
                    end else if (rel < REL_ACK) begin
                        n_seq = {r_seq[23:0], i_data_byte};
                    end else if (rel < REL_DOFF) begin
                        n_ack = {r_ack[23:0], i_data_byte};
                    end else if (rel == REL_DOFF) begin
                        n_tcp_hdr_len = {i_data_byte[7:4] & NIBBLE_MASK, 2'b00};
                    end else if (rel == REL_FLAGS) begin
                        n_flags = i_data_byte;
                    end
                end
            end
        end
    end

    // Gather the finished packet into one record
    always_comb begin
        n_rec.len          = n_byte_index;
        n_rec.version_ok   = n_version_ok;
        n_rec.ip_hdr_len   = n_ip_hdr_len;
        n_rec.proto_tcp    = n_proto_tcp;
        n_rec.frag_nonzero = n_frag_nz;
        n_rec.src_addr     = n_src_addr;
        n_rec.dst_addr     = n_dst_addr;
        n_rec.src_port     = n_src_port;
        n_rec.dst_port     = n_dst_port;
        n_rec.seq          = n_seq;
        n_rec.ack          = n_ack;
        n_rec.flags        = n_flags;
        n_rec.tcp_hdr_len  = n_tcp_hdr_len;
    end

    // Advance the packet state; clear it after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_byte_index  <= '0;
            r_version_ok  <= 1'b0;
            r_ip_hdr_len  <= '0;
            r_proto_tcp   <= 1'b0;
            r_frag_nz     <= 1'b0;
            r_src_addr    <= '0;
            r_dst_addr    <= '0;
            r_src_port    <= '0;
            r_dst_port    <= '0;
            r_seq         <= '0;
            r_ack         <= '0;
            r_flags       <= '0;
            r_tcp_hdr_len <= '0;
        end else if (accept) begin
            r_byte_index  <= n_byte_index;
            r_version_ok  <= n_version_ok;
            r_ip_hdr_len  <= n_ip_hdr_len;
            r_proto_tcp   <= n_proto_tcp;
            r_frag_nz     <= n_frag_nz;
            r_src_addr    <= n_src_addr;
            r_dst_addr    <= n_dst_addr;
            r_src_port    <= n_src_port;
            r_dst_port    <= n_dst_port;
            r_seq         <= n_seq;
            r_ack         <= n_ack;
            r_flags       <= n_flags;
            r_tcp_hdr_len <= n_tcp_hdr_len;
        end
    end

    // Hold the record until the result stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_valid <= 1'b0;
        end else if (accept && i_last_byte) begin
            r_rec_valid <= 1'b1;
        end else if (i_rec_ready) begin
            r_rec_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

endmodule

/* rtl/core/ithp_result.sv */
// Result stage: checks a packet record, orients it against the server port
// and holds the result in the output register. Depends on ithp_pkg, ithp_if.
module ithp_result (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rec_valid,
    input  ithp_pkg::t_pkt_rec i_rec,
    output logic               o_rec_ready,
    input  logic [15:0]        i_srv_port,
    ithp_res_if.source         o_res
);
    import ithp_pkg::*;

    logic        r_out_valid;
    t_result     r_out;
    t_result     n_out;

    logic        load;
    logic [16:0] len_ext;
    logic [16:0] ihl_plus_min;
    logic [6:0]  hdr_sum;
    logic        pkt_ok;
    logic        dst_is_srv;
    logic        src_is_srv;

    assign o_rec_ready = !r_out_valid || o_res.ready;
    assign load        = i_rec_valid && o_rec_ready;

    assign len_ext      = {1'b0, i_rec.len};
    assign ihl_plus_min = 17'(i_rec.ip_hdr_len) + 17'(MIN_HDR_BYTES);
    assign hdr_sum      = 7'(i_rec.ip_hdr_len) + 7'(i_rec.tcp_hdr_len);
    assign dst_is_srv   = (i_rec.dst_port == i_srv_port);
    assign src_is_srv   = (i_rec.src_port == i_srv_port);

    // Reject malformed, fragmented or non-TCP packets
    assign pkt_ok = (i_rec.len >= MIN_PACKET_BYTES) && i_rec.version_ok && i_rec.proto_tcp
                 && (i_rec.ip_hdr_len >= MIN_HDR_BYTES) && (len_ext >= ihl_plus_min)
                 && !i_rec.frag_nonzero && (i_rec.tcp_hdr_len >= MIN_HDR_BYTES)
                 && (i_rec.len >= t_len'(hdr_sum));

    // Build the result; the destination port is tested first
    always_comb begin
        n_out = '0;
        if (pkt_ok) begin
            if (dst_is_srv || !src_is_srv) begin
                n_out.status   = dst_is_srv ? ST_CLI_TO_SRV : ST_NO_MATCH;
                n_out.cli_addr = i_rec.src_addr;
                n_out.srv_addr = i_rec.dst_addr;
                n_out.cli_port = i_rec.src_port;
                n_out.srv_port = i_rec.dst_port;
            end else begin
                n_out.status   = ST_SRV_TO_CLI;
                n_out.cli_addr = i_rec.dst_addr;
                n_out.srv_addr = i_rec.src_addr;
                n_out.cli_port = i_rec.dst_port;
                n_out.srv_port = i_rec.src_port;
            end
            n_out.flag_byte             = i_rec.flags;
            n_out.sequence_after_header = i_rec.seq + 32'(i_rec.tcp_hdr_len);
            n_out.seq_raw               = i_rec.seq;
            n_out.acknowledgement       = i_rec.ack;
            n_out.payload_offset        = hdr_sum;
            n_out.pay_len               = i_rec.len - t_len'(hdr_sum);
        end
    end

    // Output register: load when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid                 = r_out_valid;
    assign o_res.status                = r_out.status;
    assign o_res.cli_addr              = r_out.cli_addr;
    assign o_res.srv_addr              = r_out.srv_addr;
    assign o_res.cli_port              = r_out.cli_port;
    assign o_res.srv_port              = r_out.srv_port;
    assign o_res.flag_byte             = r_out.flag_byte;
    assign o_res.sequence_after_header = r_out.sequence_after_header;
    assign o_res.seq_raw               = r_out.seq_raw;
    assign o_res.acknowledgement       = r_out.acknowledgement;
    assign o_res.payload_offset        = r_out.payload_offset;
    assign o_res.pay_len               = r_out.pay_len;

endmodule

/* rtl/core/ipv4_tcp_header_parser.sv */
// IPv4/TCP header parser: one packet byte per request in, one result per packet out.
// Top level of the block; depends on ithp_pkg, ithp_if, ithp_apb_regs,
// ithp_capture and ithp_result.
//
// Usage:
//   i_pkt carries packet bytes in wire order from the first IPv4 header
//   byte; last_byte marks the end of a packet. A byte is taken on every
//   cycle with valid and ready high, so bytes stream one per cycle unless ready drops.
//   o_res carries one result per packet: status 0 for a rejected packet
//   (all other fields zero), else the addresses, ports, sequence numbers,
//   flags and payload offset/length, oriented against the server port.
//   The APB port holds the server port at address 0; program it while idle.
// Timing:
//   The edge that accepts the last byte loads the packet record; the output
//   register takes it when empty or being drained, and o_res.valid rises
//   with that load. Throughput is one byte per cycle while ready is high.
//   The record stage acts as a skid buffer: bytes keep flowing while a
//   result waits; i_pkt.ready drops only when both the record and the
//   output register are full and o_res.ready is low.
// Reset:
//   i_rst_n (synchronous, active low) clears the packet state, empties both
//   stages and sets the server port to 0.
module ipv4_tcp_header_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ithp_byte_if.sink                       i_pkt,
    ithp_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ithp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ithp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ithp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import ithp_pkg::*;

    logic [15:0] srv_port;
    logic        rec_valid;
    logic        rec_ready;
    t_pkt_rec    rec;

    // Configuration register
    ithp_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_srv_port (srv_port)
    );

    // Byte capture and packet record
    ithp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pkt.valid),
        .i_data_byte (i_pkt.data_byte),
        .i_last_byte (i_pkt.last_byte),
        .o_ready     (i_pkt.ready),
        .o_rec_valid (rec_valid),
        .o_rec       (rec),
        .i_rec_ready (rec_ready)
    );

    // Checks, orientation and output register
    ithp_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .i_rec       (rec),
        .o_rec_ready (rec_ready),
        .i_srv_port  (srv_port),
        .o_res       (o_res)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_tcp_header_parser: streams IPv4/TCP packets
// bytewise, predicts each parse result and checks it field by field.
// Depends on ithp_pkg, ithp_if and the parser RTL.
module testbench;
    import ithp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] SRV_PORT_ADDR = APB_ADDR_W'(4 * REG_SRV_PORT);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ithp_byte_if pkt_if ();
    ithp_res_if  res_if ();

    ipv4_tcp_header_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (pkt_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Byte requests waiting for the link, parse results waiting for the output
    t_byte_req   link_bytes[$];
    t_result     flow_results_due[$];
    logic [7:0]  frame[$];
    int unsigned mismatch_count = 0;

    // Idle control
    logic        send_idle = 1'b0;
    logic        sink_idle = 1'b0;
    logic        byte_taken = 1'b0;
    int unsigned send_gap = 0;
    int unsigned sink_gap = 0;

    // Parser shadow state
    logic [15:0] srv_port_cfg = '0;
    int unsigned pkt_len = 0;
    int unsigned ip_hlen = 0;
    int unsigned tcp_hlen = 0;
    logic        ver_ok = 1'b0;
    logic        proto_ok = 1'b0;
    logic        frag_bad = 1'b0;
    logic [31:0] src_ip = '0;
    logic [31:0] dst_ip = '0;
    logic [15:0] src_prt = '0;
    logic [15:0] dst_prt = '0;
    logic [31:0] seq_num = '0;
    logic [31:0] ack_num = '0;
    logic [7:0]  flag_bits = '0;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap(input logic enabled);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Advance the packet capture by one byte; on the last byte predict the result
    task automatic parse_packet_byte(input logic [7:0] b, input logic last);
        int unsigned rel;
        logic        ok;
        t_result     r;
        if (pkt_len < MAX_PACKET_BYTES) begin
            if (pkt_len == POS_VER_IHL) begin
                ver_ok  = (b[7:4] == IP_VERSION_4);
                ip_hlen = 4 * (b[3:0] & NIBBLE_MASK);
            end else begin
                if (pkt_len == POS_FRAG_HI) frag_bad = (b[4:0] & FRAG_HIGH_MASK) != '0;
                if (pkt_len == POS_FRAG_LO) frag_bad = frag_bad || (b != '0);
                if (pkt_len == POS_PROTO) proto_ok = (b == PROTO_TCP);
                if (pkt_len >= POS_SRC_ADDR && pkt_len < POS_DST_ADDR) begin
                    src_ip = {src_ip[23:0], b};
                end
                if (pkt_len >= POS_DST_ADDR && pkt_len < POS_IP_END) begin
                    dst_ip = {dst_ip[23:0], b};
                end
                if (pkt_len >= ip_hlen) begin
                    rel = pkt_len - ip_hlen;
                    if (rel < REL_DST_PORT) src_prt = {src_prt[7:0], b};
                    else if (rel < REL_SEQ) dst_prt = {dst_prt[7:0], b};
                    else if (rel < REL_ACK) seq_num = {seq_num[23:0], b};
                    else if (rel < REL_DOFF) ack_num = {ack_num[23:0], b};
                    else if (rel == REL_DOFF) tcp_hlen = 4 * ((b >> 4) & NIBBLE_MASK);
                    else if (rel == REL_FLAGS) flag_bits = b;
                end
            end
            pkt_len++;
        end
        if (!last) return;

        ok = pkt_len >= MIN_PACKET_BYTES && ver_ok && proto_ok
            && ip_hlen >= MIN_HDR_BYTES && pkt_len >= ip_hlen + MIN_HDR_BYTES
            && !frag_bad && tcp_hlen >= MIN_HDR_BYTES && pkt_len >= ip_hlen + tcp_hlen;
        r = '0;
        r.status = ST_REJECT;
        if (ok) begin
            // Orient the flow: destination port wins when both match
            if (dst_prt == srv_port_cfg || src_prt != srv_port_cfg) begin
                r.status   = (dst_prt == srv_port_cfg) ? ST_CLI_TO_SRV : ST_NO_MATCH;
                r.cli_addr = src_ip;
                r.srv_addr = dst_ip;
                r.cli_port = src_prt;
                r.srv_port = dst_prt;
            end else begin
                r.status   = ST_SRV_TO_CLI;
                r.cli_addr = dst_ip;
                r.srv_addr = src_ip;
                r.cli_port = dst_prt;
                r.srv_port = src_prt;
            end
            r.flag_byte             = flag_bits;
            r.sequence_after_header = seq_num + 32'(tcp_hlen);
            r.seq_raw               = seq_num;
            r.acknowledgement       = ack_num;
            r.payload_offset        = 7'(ip_hlen + tcp_hlen);
            r.pay_len               = 16'(pkt_len - ip_hlen - tcp_hlen);
        end
        flow_results_due.push_back(r);

        // Drop the packet state
        pkt_len   = 0;
        ip_hlen   = 0;
        tcp_hlen  = 0;
        ver_ok    = 1'b0;
        proto_ok  = 1'b0;
        frag_bad  = 1'b0;
        src_ip    = '0;
        dst_ip    = '0;
        src_prt   = '0;
        dst_prt   = '0;
        seq_num   = '0;
        ack_num   = '0;
        flag_bits = '0;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", field, got, want));
        end
    endtask

    // Sample handshakes: check results, then feed accepted bytes to the prediction
    always @(posedge i_clk) begin
        t_result want;
        byte_taken <= i_rst_n && pkt_if.valid && pkt_if.ready;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (flow_results_due.size() == 0) begin
                flag_mismatch("result request with no packet pending");
            end else begin
                want = flow_results_due.pop_front();
                compare_field("status", 32'(res_if.status), 32'(want.status));
                compare_field("cli_addr", res_if.cli_addr, want.cli_addr);
                compare_field("srv_addr", res_if.srv_addr, want.srv_addr);
                compare_field("cli_port", 32'(res_if.cli_port), 32'(want.cli_port));
                compare_field("srv_port", 32'(res_if.srv_port), 32'(want.srv_port));
                compare_field("flag_byte", 32'(res_if.flag_byte), 32'(want.flag_byte));
                compare_field("sequence_after_header", res_if.sequence_after_header,
                              want.sequence_after_header);
                compare_field("seq_raw", res_if.seq_raw, want.seq_raw);
                compare_field("acknowledgement", res_if.acknowledgement, want.acknowledgement);
                compare_field("payload_offset", 32'(res_if.payload_offset),
                              32'(want.payload_offset));
                compare_field("pay_len", 32'(res_if.pay_len), 32'(want.pay_len));
            end
        end
        if (i_rst_n && pkt_if.valid && pkt_if.ready) begin
            parse_packet_byte(pkt_if.data_byte, pkt_if.last_byte);
        end
    end

    // Byte driver: hold an unaccepted request, otherwise idle or advance the queue
    always @(negedge i_clk) begin
        t_byte_req next_req;
        if (!i_rst_n) begin
            pkt_if.valid <= 1'b0;
        end else if (pkt_if.valid && !byte_taken) begin
            pkt_if.valid <= 1'b1;
        end else if (send_gap > 0) begin
            pkt_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
        end else if (link_bytes.size() > 0) begin
            next_req = link_bytes.pop_front();
            pkt_if.valid     <= 1'b1;
            pkt_if.data_byte <= next_req.data;
            pkt_if.last_byte <= next_req.last;
            send_gap         <= pick_gap(send_idle);
        end else begin
            pkt_if.valid <= 1'b0;
        end
    end

    // Result sink: stall ready at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            res_if.ready <= 1'b0;
            sink_gap     <= sink_gap - 1;
        end else begin
            res_if.ready <= 1'b1;
            sink_gap     <= pick_gap(sink_idle);
        end
    end

    // Build a well-formed IPv4/TCP packet with random content into frame
    task automatic make_frame(input int unsigned ihl_w, input int unsigned thl_w,
                              input int unsigned pay_len, input logic [15:0] sp,
                              input logic [15:0] dp);
        int unsigned tcp_at;
        int unsigned total;
        tcp_at = 4 * ihl_w;
        total  = tcp_at + 4 * thl_w + pay_len;
        frame.delete();
        repeat (total) frame.push_back(8'($urandom));
        frame[0]          = {IP_VERSION_4, 4'(ihl_w)};
        frame[6]          = frame[6] & 8'he0;
        frame[7]          = 8'h00;
        frame[9]          = PROTO_TCP;
        frame[tcp_at]     = sp[15:8];
        frame[tcp_at + 1] = sp[7:0];
        frame[tcp_at + 2] = dp[15:8];
        frame[tcp_at + 3] = dp[7:0];
        frame[tcp_at + REL_DOFF] = {4'(thl_w), frame[tcp_at + REL_DOFF][3:0]};
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++) begin
            link_bytes.push_back({frame[i], i == frame.size() - 1});
        end
    endtask

    task automatic fill_frame(input int unsigned count, input logic [7:0] value);
        frame.delete();
        repeat (count) frame.push_back(value);
    endtask

    // Random packet: mostly well-formed, some broken, some pure noise
    task automatic random_packet();
        int unsigned kind;
        int unsigned ihl_w;
        int unsigned thl_w;
        int unsigned pay;
        logic [15:0] sp;
        logic [15:0] dp;
        kind  = $urandom_range(0, 99);
        ihl_w = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        thl_w = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
        pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        sp    = 16'($urandom);
        dp    = 16'($urandom);
        case ($urandom_range(0, 3))
            0: dp = srv_port_cfg;
            1: sp = srv_port_cfg;
            2: begin
                sp = srv_port_cfg;
                dp = srv_port_cfg;
            end
            default: ;
        endcase
        if (kind >= 90) begin
            frame.delete();
            repeat ($urandom_range(1, 80)) frame.push_back(8'($urandom));
        end else begin
            make_frame(ihl_w, thl_w, pay, sp, dp);
            if (kind >= 70) begin
                case ($urandom_range(0, 6))
                    0: frame[0] = {4'($urandom_range(0, 15)), frame[0][3:0]};
                    1: frame[POS_PROTO] = 8'($urandom);
                    2: frame[POS_FRAG_HI] = {frame[POS_FRAG_HI][7:5], 5'($urandom_range(1, 31))};
                    3: frame[POS_FRAG_LO] = 8'($urandom_range(1, 255));
                    4: frame[0] = {frame[0][7:4], 4'($urandom_range(0, 4))};
                    5: frame[4 * ihl_w + REL_DOFF] = {4'($urandom_range(0, 4)),
                                                      frame[4 * ihl_w + REL_DOFF][3:0]};
                    default: repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
                endcase
            end
        end
        send_frame();
    endtask

    // Hold until the link and the result side are both quiet
    task automatic wait_idle();
        while (link_bytes.size() != 0 || pkt_if.valid || flow_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Write the server port over APB, then read it back
    task automatic set_srv_port(input logic [15:0] port);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= SRV_PORT_ADDR;
        pwdata  <= {16'b0, port};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        srv_port_cfg = port;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== port) begin
            flag_mismatch($sformatf("server port read 0x%0h, want 0x%0h", prdata[15:0], port));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int unsigned phase_bytes;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pkt_if.valid     = 1'b0;
        pkt_if.data_byte = '0;
        pkt_if.last_byte = 1'b0;
        res_if.ready     = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases
        set_srv_port(16'd80);
        send_idle = 1'b0;
        sink_idle = 1'b1;
        // port orientation: to server, from server, both ports, neither
        make_frame(5, 5, 0, 16'd1234, 16'd80);
        send_frame();
        make_frame(5, 5, 4, 16'd80, 16'd5555);
        send_frame();
        make_frame(5, 5, 1, 16'd80, 16'd80);
        send_frame();
        make_frame(5, 5, 3, 16'd1000, 16'd2000);
        send_frame();
        // one byte short of the minimum length
        make_frame(5, 5, 0, 16'd1, 16'd80);
        void'(frame.pop_back());
        send_frame();
        // last mark on the very first byte
        fill_frame(1, 8'h45);
        send_frame();
        // wrong version, then wrong protocol
        make_frame(5, 5, 2, 16'd7, 16'd80);
        frame[0] = 8'h65;
        send_frame();
        make_frame(5, 5, 2, 16'd7, 16'd80);
        frame[POS_PROTO] = 8'd17;
        send_frame();
        // IP header length below minimum, and zero
        make_frame(4, 5, 10, 16'd9, 16'd80);
        send_frame();
        make_frame(5, 5, 20, 16'd9, 16'd80);
        frame[0] = 8'h40;
        send_frame();
        // nonzero fragment offset in the high bits, then in the low byte
        make_frame(5, 5, 0, 16'd11, 16'd80);
        frame[POS_FRAG_HI] = 8'h01;
        send_frame();
        make_frame(5, 5, 0, 16'd11, 16'd80);
        frame[POS_FRAG_LO] = 8'h80;
        send_frame();
        // TCP header length below minimum
        make_frame(5, 4, 20, 16'd12, 16'd80);
        send_frame();
        // largest headers: truncated, then exact with no payload
        make_frame(15, 15, 0, 16'd80, 16'hffff);
        repeat (10) void'(frame.pop_back());
        send_frame();
        make_frame(15, 15, 0, 16'd80, 16'hffff);
        send_frame();
        // sequence number wraps when the header length is added
        make_frame(5, 5, 6, 16'hffff, 16'd80);
        for (int i = 0; i < 4; i++) frame[POS_IP_END + REL_SEQ + i] = 8'hff;
        send_frame();
        // all-zero and all-ones packets
        fill_frame(40, 8'h00);
        send_frame();
        fill_frame(40, 8'hff);
        send_frame();
        wait_idle();

        // Random phases, each with its own server port and idle pattern
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_srv_port(16'd0);
                1: set_srv_port(16'hffff);
                2: set_srv_port(16'd443);
                default: set_srv_port(16'($urandom));
            endcase
            send_idle   = (ph != 0) && ($urandom_range(0, 3) != 0);
            sink_idle   = (ph != 0) && ($urandom_range(0, 3) != 0);
            phase_bytes = 0;
            while (phase_bytes < 80) begin
                random_packet();
                phase_bytes += frame.size();
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (flow_results_due.size() != 0) begin
            flag_mismatch($sformatf("%0d parse results never arrived", flow_results_due.size()));
        end
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
